// File: rtl/spc_pkg.sv
// shared types, widths and constants of the speed pid controller
package spc_pkg;

    // field widths
    localparam int ADC_W      = 10;
    localparam int CNT_PORT_W = 16;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 10;
    localparam int SP_W       = 15;
    localparam int SPEED_W    = 27;
    localparam int INTEG_W    = 40;
    localparam int ERR_W      = 28;
    localparam int DERR_W     = ERR_W + 1;
    localparam int CFG_IDX_W  = 2;

    // default for the period count width
    localparam int PERIOD_COUNT_BITS_DEF = 16;

    // shared multiplier and term widths
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = DERR_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = PROD_W - 8;
    localparam int TOTAL_W = INTEG_W + 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    // register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd20480;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd154;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd512;

    // set point: 1280 + (code * 16256 + 500) / 1000, all Q.8
    localparam int SP_SCALE   = 16256;
    localparam int SP_ROUND   = 500;
    localparam int SP_OFFSET  = 1280;
    localparam int SP_NUM_W   = 24;

    // divide by 1000 as multiply by ceil(2^34 / 1000) and shift by 34,
    // exact for any 24-bit numerator
    localparam int                    SP_RECIP_W     = 25;
    localparam logic [SP_RECIP_W-1:0] SP_RECIP       = 25'd17179870;
    localparam int                    SP_RECIP_SHIFT = 34;

    // speed numerator, 312500 Hz in Q.8
    localparam int SPEED_NUM = 80000000;

    // upper drive limit, 1023 in Q.8
    localparam int DRIVE_MAX_Q8 = 261888;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP_MUL,
        ST_SP_DIV,
        ST_SP_ADD,
        ST_SPEED,
        ST_SPEED_WAIT,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_OUT
    } state_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load_in;
        logic sp_mul;
        logic sp_div;
        logic sp_take;
        logic spd_div_start;
        logic spd_take;
        logic spd_sat;
        logic err_calc;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic sum;
        logic out_load;
    } ctrl_cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic fresh;
        logic count_zero;
        logic div_done;
    } dp_status_t;

endpackage

// File: rtl/spc_div.sv
// serial restoring divider, one quotient bit per cycle
module spc_div
    import spc_pkg::*;
#(
    parameter int NUM_W = SPEED_W,
    parameter int DEN_W = PERIOD_COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] work_reg;
    logic [NUM_W-1:0] work_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_shift;
    logic             q_bit;

    // one trial subtraction
    always_comb begin
        rem_shift = {rem_reg, work_reg[NUM_W-1]};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        rem_next  = q_bit ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
        work_next = {work_reg[NUM_W-2:0], q_bit};
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

// File: rtl/spc_datapath.sv
// datapath: gain registers, loop state, shared multiplier, divider, output word
module spc_datapath
    import spc_pkg::*;
#(
    parameter int PERIOD_COUNT_BITS = PERIOD_COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [GAIN_W-1:0]     cfg_wr_data,
    input  logic [ADC_W-1:0]      s_adc_code,
    input  logic [CNT_PORT_W-1:0] s_period_count,
    input  logic                  s_period_valid,
    output logic [DRIVE_W-1:0]    m_drive,
    output logic [SP_W-1:0]       m_set_point_hz,
    output logic [SPEED_W-1:0]    m_speed_hz
);

    localparam int CNT_W = (PERIOD_COUNT_BITS < CNT_PORT_W) ? PERIOD_COUNT_BITS : CNT_PORT_W;

    // gains
    logic [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;

    // loop state
    logic [SPEED_W-1:0]       held_speed_reg;
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [ERR_W-1:0]   last_err_reg;

    // per-word working registers
    logic [ADC_W-1:0]          code_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      fresh_reg;
    logic [SP_W-1:0]           sp_quot_reg;
    logic [SP_W-1:0]           sp_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [TERM_W-1:0]  pterm_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [DRIVE_W-1:0]        drive_reg;
    logic [SP_W-1:0]           sp_out_reg;
    logic [SPEED_W-1:0]        speed_out_reg;

    // combinational values
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  product;
    logic signed [PROD_W-1:0]  prod_shift;
    logic signed [TERM_W-1:0]  term;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [DERR_W-1:0]  derr;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integral_next;
    logic signed [TOTAL_W-1:0] total_next;
    logic [DRIVE_W-1:0]        drive_next;
    logic [SP_NUM_W-1:0]       sp_num;
    logic [SP_NUM_W+SP_RECIP_W-1:0] sp_recip_prod;
    logic                      div_done;
    logic [SPEED_W-1:0]        div_quot;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= PROP_GAIN_RST;
            ki_reg <= INTEG_GAIN_RST;
            kd_reg <= DERIV_GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROP_GAIN:  kp_reg <= cfg_wr_data;
                REG_INTEG_GAIN: ki_reg <= cfg_wr_data;
                REG_DERIV_GAIN: kd_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // error and its difference
    always_comb begin
        err_next = $signed({{(ERR_W - SP_W){1'b0}}, sp_reg}) - $signed({1'b0, held_speed_reg});
        derr     = $signed({err_reg[ERR_W-1], err_reg})
                 - $signed({last_err_reg[ERR_W-1], last_err_reg});
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sp_mul) begin
            mul_a = MUL_A_W'(SP_SCALE);
            mul_b = $signed({{(MUL_B_W - ADC_W){1'b0}}, code_reg});
        end else if (cmd.mul_p) begin
            mul_a = $signed({1'b0, kp_reg});
            mul_b = $signed({{(MUL_B_W - ERR_W){err_reg[ERR_W-1]}}, err_reg});
        end else if (cmd.mul_i) begin
            mul_a = $signed({1'b0, ki_reg});
            mul_b = $signed({{(MUL_B_W - ERR_W){err_reg[ERR_W-1]}}, err_reg});
        end else if (cmd.mul_d) begin
            mul_a = $signed({1'b0, kd_reg});
            mul_b = $signed({derr[DERR_W-1], derr});
        end
        product = mul_a * mul_b;
    end

    // floor of the last product over 256, integral saturation, sum, clamp
    always_comb begin
        prod_shift    = prod_reg >>> 8;
        term          = prod_shift[TERM_W-1:0];
        integ_sum     = $signed({integral_reg[INTEG_W-1], integral_reg})
                      + $signed({{(INTEG_W + 1 - TERM_W){term[TERM_W-1]}}, term});
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integral_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                               : {1'b0, {(INTEG_W - 1){1'b1}}};
        end else begin
            integral_next = integ_sum[INTEG_W-1:0];
        end
        total_next = $signed({{(TOTAL_W - TERM_W){pterm_reg[TERM_W-1]}}, pterm_reg})
                   + $signed({{(TOTAL_W - INTEG_W){integral_reg[INTEG_W-1]}}, integral_reg})
                   + $signed({{(TOTAL_W - TERM_W){term[TERM_W-1]}}, term});
        if (total_reg[TOTAL_W-1]) begin
            drive_next = '0;
        end else if (total_reg > $signed(TOTAL_W'(DRIVE_MAX_Q8))) begin
            drive_next = '1;
        end else begin
            drive_next = total_reg[DRIVE_W+7:8];
        end
    end

    // set point numerator, divided by 1000 through the reciprocal
    always_comb begin
        sp_num        = prod_reg[SP_NUM_W-1:0] + SP_NUM_W'(SP_ROUND);
        sp_recip_prod = {{SP_RECIP_W{1'b0}}, sp_num} * {{SP_NUM_W{1'b0}}, SP_RECIP};
    end

    // speed divider: fixed numerator over the period count
    spc_div #(
        .NUM_W (SPEED_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.spd_div_start),
        .num     (SPEED_W'(SPEED_NUM)),
        .den     (count_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // loop state across words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_speed_reg <= '0;
            integral_reg   <= '0;
            last_err_reg   <= '0;
        end else begin
            if (cmd.spd_take) begin
                held_speed_reg <= div_quot;
            end else if (cmd.spd_sat) begin
                held_speed_reg <= SPEED_W'(SPEED_NUM);
            end
            if (cmd.mul_d) begin
                integral_reg <= integral_next;
            end
            if (cmd.sum) begin
                last_err_reg <= err_reg;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            code_reg  <= s_adc_code;
            count_reg <= s_period_count[CNT_W-1:0];
            fresh_reg <= s_period_valid;
        end
        if (cmd.sp_mul || cmd.mul_p || cmd.mul_i || cmd.mul_d) begin
            prod_reg <= product;
        end
        if (cmd.sp_div) begin
            sp_quot_reg <= sp_recip_prod[SP_RECIP_SHIFT +: SP_W];
        end
        if (cmd.sp_take) begin
            sp_reg <= SP_W'(SP_OFFSET) + sp_quot_reg;
        end
        if (cmd.err_calc) begin
            err_reg <= err_next;
        end
        if (cmd.mul_i) begin
            pterm_reg <= term;
        end
        if (cmd.sum) begin
            total_reg <= total_next;
        end
        if (cmd.out_load) begin
            drive_reg     <= drive_next;
            sp_out_reg    <= sp_reg;
            speed_out_reg <= held_speed_reg;
        end
    end

    assign status.fresh      = fresh_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.div_done   = div_done;

    assign m_drive        = drive_reg;
    assign m_set_point_hz = sp_out_reg;
    assign m_speed_hz     = speed_out_reg;

endmodule

// File: rtl/spc_ctrl.sv
// sequencer: handshakes and step commands for the datapath
module spc_ctrl
    import spc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SP_MUL;
                end
            end
            ST_SP_MUL: begin
                cmd.sp_mul = 1'b1;
                state_next = ST_SP_DIV;
            end
            ST_SP_DIV: begin
                cmd.sp_div = 1'b1;
                state_next = ST_SP_ADD;
            end
            ST_SP_ADD: begin
                cmd.sp_take = 1'b1;
                state_next  = ST_SPEED;
            end
            ST_SPEED: begin
                if (status.fresh && !status.count_zero) begin
                    cmd.spd_div_start = 1'b1;
                    state_next        = ST_SPEED_WAIT;
                end else begin
                    cmd.spd_sat = status.fresh;
                    state_next  = ST_ERR;
                end
            end
            ST_SPEED_WAIT: begin
                if (status.div_done) begin
                    cmd.spd_take = 1'b1;
                    state_next   = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.err_calc = 1'b1;
                state_next   = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.mul_p  = 1'b1;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                cmd.mul_i  = 1'b1;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.mul_d  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/speed_pid_controller_unit.sv
// Speed PID controller, top level.
// One input word is one pass of the control loop: potentiometer code, period
// tick count and a flag that marks the count as fresh. One output word comes
// back per input word: clamped drive, set point (Q.8 Hz), measured speed (Q.8 Hz).
// Both channels use valid/ready. Gains are written through the cfg port
// (index 0 prop, 1 integral, 2 derivative); the user must write them only
// while the block is idle, which the block itself does not enforce. When the
// count is fresh and nonzero, the speed comes from the serial divider, one
// quotient bit per cycle over 27 bits; otherwise the divider is not used.
// The set point divide by 1000 is a reciprocal multiply; the gain products
// share one multiplier. A new input word is taken in the cycle after the
// previous result is loaded into the output register, and none while a word
// is being processed. A result may wait in the output register while the
// next word is processed; if the receiver still stalls when the next result
// is ready, the block holds in its final step until the output register frees.
// Reset (aresetn low, synchronous) restores the default gains, clears the
// held speed, integral and previous error, and empties the output register.
module speed_pid_controller_unit
    import spc_pkg::*;
#(
    parameter int PERIOD_COUNT_BITS = PERIOD_COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [GAIN_W-1:0]     cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADC_W-1:0]      s_adc_code,
    input  logic [CNT_PORT_W-1:0] s_period_count,
    input  logic                  s_period_valid,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DRIVE_W-1:0]    m_drive,
    output logic [SP_W-1:0]       m_set_point_hz,
    output logic [SPEED_W-1:0]    m_speed_hz
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    spc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath
    spc_datapath #(
        .PERIOD_COUNT_BITS (PERIOD_COUNT_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_adc_code     (s_adc_code),
        .s_period_count (s_period_count),
        .s_period_valid (s_period_valid),
        .m_drive        (m_drive),
        .m_set_point_hz (m_set_point_hz),
        .m_speed_hz     (m_speed_hz)
    );

endmodule

// File: rtl/spc_checker.sv
// port-level checks of the speed pid controller, bound to the top level
module spc_checker
    import spc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [DRIVE_W-1:0] m_drive,
    input logic [SP_W-1:0]    m_set_point_hz
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    // an accepted input word keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after acceptance");

    // set point always lies in its range
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_set_point_hz >= SP_W'(SP_OFFSET)) && (m_set_point_hz <= SP_W'(17910)))
        else $error("set point out of range");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_drive) && $stable(m_set_point_hz))
        else $error("stalled output word changed");

endmodule

bind speed_pid_controller_unit spc_checker u_spc_checker (.*);

// File: test/testbench.sv
// self-checking testbench of the speed pid controller unit
`timescale 1ns / 100ps

module testbench
    import spc_pkg::*;
();

    // run control
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 70;
    localparam int MAX_REPORTS    = 10;

    // register index that maps to nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // loop arithmetic, all Q.8
    localparam longint SET_BASE_Q8  = 1280;
    localparam longint SET_SLOPE    = 162560;
    localparam longint SET_HALF     = 5000;
    localparam longint SET_DIV      = 10000;
    localparam longint SPEED_TOP_Q8 = 80000000;
    localparam longint INTEG_HI     = 64'sd549755813887;
    localparam longint INTEG_LO     = -64'sd549755813888;
    localparam longint DRIVE_TOP_Q8 = 261888;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [SP_W-1:0]    target;
        logic [SPEED_W-1:0] speed;
    } loop_result_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [GAIN_W-1:0]     cfg_wr_data    = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [ADC_W-1:0]      s_adc_code     = '0;
    logic [CNT_PORT_W-1:0] s_period_count = '0;
    logic                  s_period_valid = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [DRIVE_W-1:0]    m_drive;
    logic [SP_W-1:0]       m_set_point_hz;
    logic [SPEED_W-1:0]    m_speed_hz;

    // predicted gains and loop state
    logic [GAIN_W-1:0]  kp_model = PROP_GAIN_RST;
    logic [GAIN_W-1:0]  ki_model = INTEG_GAIN_RST;
    logic [GAIN_W-1:0]  kd_model = DERIV_GAIN_RST;
    logic [SPEED_W-1:0] speed_model = '0;
    longint             integ_model = 0;
    longint             prev_err_model = 0;

    loop_result_t expected_results[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           quiet_cycles   = 0;
    logic         hold_req       = 1'b0;
    logic         hold_taken     = 1'b0;

    speed_pid_controller_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_adc_code     (s_adc_code),
        .s_period_count (s_period_count),
        .s_period_valid (s_period_valid),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive),
        .m_set_point_hz (m_set_point_hz),
        .m_speed_hz     (m_speed_hz)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // one control pass of the loop: set point, speed, pid sum and clamp
    function automatic loop_result_t predict_pass(input logic [ADC_W-1:0] code,
                                                  input logic [CNT_PORT_W-1:0] count,
                                                  input logic fresh);
        longint       sp;
        longint       err;
        longint       p_term;
        longint       i_term;
        longint       d_term;
        longint       total;
        loop_result_t res;
        sp = SET_BASE_Q8 + (longint'(code) * SET_SLOPE + SET_HALF) / SET_DIV;
        if (fresh) begin
            if (count == '0)
                speed_model = SPEED_TOP_Q8[SPEED_W-1:0];
            else
                speed_model = SPEED_W'(SPEED_TOP_Q8 / longint'(count));
        end
        err = sp - longint'(speed_model);
        // arithmetic shift of a signed product rounds toward minus infinity
        p_term = (longint'(kp_model) * err) >>> 8;
        i_term = integ_model + ((longint'(ki_model) * err) >>> 8);
        if (i_term > INTEG_HI)
            i_term = INTEG_HI;
        if (i_term < INTEG_LO)
            i_term = INTEG_LO;
        d_term = (longint'(kd_model) * (err - prev_err_model)) >>> 8;
        total = p_term + i_term + d_term;
        if (total > DRIVE_TOP_Q8)
            total = DRIVE_TOP_Q8;
        if (total < 0)
            total = 0;
        integ_model    = i_term;
        prev_err_model = err;
        res.drive  = DRIVE_W'(total >>> 8);
        res.target = SP_W'(sp);
        res.speed  = speed_model;
        return res;
    endfunction

    // one register write, mirrored into the predicted gains
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            REG_PROP_GAIN: begin
                kp_model = data;
            end
            REG_INTEG_GAIN: begin
                ki_model = data;
            end
            REG_DERIV_GAIN: begin
                kd_model = data;
            end
            default: begin
            end
        endcase
    endtask

    // all three gains plus a write to the unused index, which must be ignored
    task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd);
        write_reg(REG_UNUSED, GAIN_W'($urandom_range(0, 65535)));
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        cfg_wr_en <= 1'b0;
    endtask

    // present one word, wait for acceptance, then predict its result
    task automatic send_word(input logic [ADC_W-1:0] code, input logic [CNT_PORT_W-1:0] count,
                             input logic fresh);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_adc_code     <= code;
        s_period_count <= count;
        s_period_valid <= fresh;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_results.push_back(predict_pass(code, count, fresh));
    endtask

    // random word: counts weighted toward the operating range, zero and tiny counts too
    task automatic send_random_word();
        int                    pick;
        logic [CNT_PORT_W-1:0] count;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            count = '0;
        else if (pick < 22)
            count = CNT_PORT_W'($urandom_range(1, 255));
        else if (pick < 72)
            count = CNT_PORT_W'($urandom_range(4000, 65535));
        else
            count = CNT_PORT_W'($urandom_range(0, 65535));
        send_word(ADC_W'($urandom_range(0, 1023)), count, ($urandom_range(0, 99) < 75));
    endtask

    // drop valid and wait until every expected word has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // reset gains and zero state, before any register write
    task automatic test_reset_defaults();
        send_word('0, '0, 1'b0);
        send_word(10'd1023, 16'hFFFF, 1'b1);
        send_word(10'd512, 16'd4464, 1'b1);
        send_word(10'h2AA, 16'h5555, 1'b1);
        send_word(10'h155, 16'hAAAA, 1'b1);
    endtask

    // zero count saturates the speed, stale count holds it
    task automatic test_count_special_cases();
        send_word(10'd700, '0, 1'b1);
        send_word(10'd700, 16'd1234, 1'b0);
        send_word(10'd1, 16'h0001, 1'b1);
        send_word(10'd300, 16'hFFFF, 1'b0);
        send_word(10'd900, 16'd9000, 1'b1);
        send_word(10'd900, '0, 1'b0);
    endtask

    // large positive error hits the upper clamp, large negative the lower one
    task automatic test_drive_clamps();
        wait_idle();
        set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST);
        send_word(10'd1023, 16'hFFFF, 1'b1);
        send_word(10'd1023, 16'hFFFF, 1'b1);
        send_word('0, 16'd2, 1'b1);
        send_word('0, 16'd2, 1'b0);
    endtask

    // all gains zero, then all gains at full scale
    task automatic test_gain_extremes();
        wait_idle();
        set_gains('0, '0, '0);
        send_word(10'd400, 16'd20000, 1'b1);
        send_word(10'd800, 16'd5000, 1'b1);
        wait_idle();
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(10'd1023, 16'd60000, 1'b1);
        send_word('0, 16'd60000, 1'b1);
    endtask

    // full integral gain with tiny counts drives the integral toward its lower limit
    task automatic test_integral_saturation();
        int n;
        wait_idle();
        set_gains(GAIN_W'($urandom_range(0, 65535)), 16'hFFFF, GAIN_W'($urandom_range(0, 65535)));
        for (n = 0; n < 45; n++)
            send_word(ADC_W'($urandom_range(0, 1023)), CNT_PORT_W'($urandom_range(0, 8)),
                      ($urandom_range(0, 3) != 0));
        for (n = 0; n < 10; n++)
            send_word(ADC_W'($urandom_range(0, 1023)), CNT_PORT_W'($urandom_range(40000, 65535)),
                      1'b1);
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_output_backpressure();
        int n;
        wait_idle();
        set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST);
        hold_req = 1'b1;
        for (n = 0; n < 10; n++)
            send_random_word();
    endtask

    // random words over several gain settings at one idling mix
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int seg;
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (seg = 0; seg < 4; seg++) begin
            wait_idle();
            case (seg)
                0: set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST);
                1: set_gains(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
                             GAIN_W'($urandom_range(0, 65535)));
                2: set_gains(GAIN_W'($urandom_range(0, 2047)), GAIN_W'($urandom_range(0, 255)),
                             GAIN_W'($urandom_range(0, 2047)));
                default: set_gains(GAIN_W'($urandom_range(0, 65535)),
                                   GAIN_W'($urandom_range(0, 1023)),
                                   GAIN_W'($urandom_range(0, 65535)));
            endcase
            for (n = 0; n < 140; n++)
                send_random_word();
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 18;
        recv_idle_pct = 81;
        test_reset_defaults();
        test_count_special_cases();
        test_drive_clamps();
        test_gain_extremes();
        test_integral_saturation();
        test_output_backpressure();
        test_random_traffic(18, 81);
        test_random_traffic(81, 18);
        test_random_traffic(0, 0);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random ready, with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each output word with the oldest prediction
    always @(posedge aclk) begin
        loop_result_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected output word: drive %0d set point %0d speed %0d",
                             m_drive, m_set_point_hz, m_speed_hz);
            end else begin
                exp_word = expected_results.pop_front();
                if (m_drive !== exp_word.drive || m_set_point_hz !== exp_word.target ||
                    m_speed_hz !== exp_word.speed) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: drive %0d/%0d set point %0d/%0d speed %0d/%0d (exp/got)",
                                 exp_word.drive, m_drive, exp_word.target, m_set_point_hz,
                                 exp_word.speed, m_speed_hz);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
